// ===== rtl/pmon_pkg.sv =====
package pmon_pkg;

   // Field widths of the channels and registers
   localparam int MODULE_MAX    = 24;
   localparam int MODULE_ID_W   = 5;
   localparam int CNT_W         = 8;
   localparam int MASK_W        = 16;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;

   // Default group sizes
   localparam int PRIMARY_COUNT_DEF   = 16;
   localparam int SECONDARY_COUNT_DEF = 8;

   // Register reset values
   localparam logic [CNT_W-1:0]  TIMEOUT_RESET = 8'd15;
   localparam logic [MASK_W-1:0] MASK_RESET    = '0;

   // Item opcodes
   typedef enum logic [1:0] {
      OP_HEARTBEAT = 2'd0,
      OP_CLEAR     = 2'd1,
      OP_TICK      = 2'd2
   } op_type;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRIMARY_VALID_MASK      = 2'd0,
      CSR_PRIMARY_TIMEOUT_TICKS   = 2'd1,
      CSR_SECONDARY_TIMEOUT_TICKS = 2'd2
   } csr_index_type;

   // Event kinds
   localparam logic KIND_RESPONDS = 1'b0;
   localparam logic KIND_MISSING  = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   // Control from the sequencer to one cell
   typedef struct packed {
      logic set_seen;
      logic clr_seen;
      logic take;
   } pmon_cell_ctl_type;

   // Status from one cell to the sequencer
   typedef struct packed {
      logic active;
      logic pend;
      logic kind;
   } pmon_cell_sts_type;

endpackage

// ===== rtl/pmon_if.sv =====
interface pmon_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [4:0] module_id;

   modport source (output valid, output opcode, output module_id, input ready);
   modport sink   (input valid, input opcode, input module_id, output ready);
endinterface

interface pmon_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_valid;
   logic        event_kind;
   logic [4:0]  event_module;
   logic [23:0] active_mask;
   logic        last_result;

   modport source (output valid, output event_valid, output event_kind,
                   output event_module, output active_mask, output last_result,
                   input ready);
   modport sink   (input valid, input event_valid, input event_kind,
                   input event_module, input active_mask, input last_result,
                   output ready);
endinterface

// ===== rtl/pmon_cell.sv =====
module pmon_cell #(
   parameter bit IS_PRIMARY = 1'b1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              token_in,
   output logic                              token_out,
   input  logic                              mon,
   input  logic [pmon_pkg::CNT_W-1:0]        timeout,
   input  pmon_pkg::pmon_cell_ctl_type       ctl,
   output pmon_pkg::pmon_cell_sts_type       sts
);
   import pmon_pkg::*;

   logic             token_ff;
   logic             seen_ff,   seen_in;
   logic             active_ff, active_in;
   logic             pend_ff,   pend_in;
   logic             kind_ff,   kind_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic [CNT_W-1:0] cnt_inc;
   logic             expire;

   // Saturating silence count and timeout compare
   assign cnt_inc = (cnt_ff == '1) ? cnt_ff : cnt_ff + CNT_W'(1);
   assign expire  = (cnt_inc >= timeout);

   // Apply heartbeat, clear and take controls; update this module when the sweep token sits here
   always_comb begin
      seen_in   = seen_ff;
      active_in = active_ff;
      pend_in   = pend_ff;
      kind_in   = kind_ff;
      cnt_in    = cnt_ff;
      if (ctl.set_seen) begin
         seen_in = 1'b1;
      end
      if (ctl.clr_seen) begin
         seen_in = 1'b0;
      end
      if (ctl.take) begin
         pend_in = 1'b0;
      end
      if (token_ff) begin
         seen_in = 1'b0;
         if (mon) begin
            priority if (seen_ff) begin
               cnt_in    = '0;
               active_in = 1'b1;
               if (!active_ff) begin
                  pend_in = 1'b1;
                  kind_in = KIND_RESPONDS;
               end
            end else if (IS_PRIMARY) begin
               if (expire) begin
                  cnt_in    = '0;
                  active_in = 1'b0;
                  pend_in   = 1'b1;
                  kind_in   = KIND_MISSING;
               end else begin
                  cnt_in = cnt_inc;
               end
            end else if (active_ff) begin
               cnt_in = cnt_inc;
               if (expire) begin
                  active_in = 1'b0;
                  pend_in   = 1'b1;
                  kind_in   = KIND_MISSING;
               end
            end else begin
               // hold the count of an inactive secondary module
               cnt_in = cnt_ff;
            end
         end
      end
   end

   // Hold module state, pass the token on
   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff  <= 1'b0;
         seen_ff   <= 1'b0;
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         token_ff  <= token_in;
         seen_ff   <= seen_in;
         active_ff <= active_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
   end

   assign token_out  = token_ff;
   assign sts.active = active_ff;
   assign sts.pend   = pend_ff;
   assign sts.kind   = kind_ff;

endmodule

// ===== rtl/module_presence_monitor_core.sv =====
// Heartbeat timeout monitor for a primary and a secondary group of modules.
// Input channel req_ch carries items: heartbeat (mark module seen), clear
// (unmark it) or tick (examine every module, then drop all seen marks).
// Result channel rsp_ch returns one or more items per input item; the last
// one has last_result set and every one carries the active mask as it
// stands after the input.
// A heartbeat, clear or unused opcode gives one result with no event; it
// can be loaded into the output register in the cycle after acceptance.
// A tick runs a token down a row of one cell per module, one cell a cycle;
// events then leave in module order while a scan pointer steps one module
// a cycle as long as the receiver keeps up.
// Input is taken only while no item is in progress; configuration writes
// on csr_* take effect at once and are meant for idle periods.
// A stalled receiver holds the output register and the scan; no result is
// dropped. Reset (synchronous, active high) clears all seen marks, active
// flags, silence counters and pending results, and restores the registers
// to mask zero and timeouts of 15 ticks.
module module_presence_monitor_core #(
   parameter int PRIMARY_COUNT   = pmon_pkg::PRIMARY_COUNT_DEF,
   parameter int SECONDARY_COUNT = pmon_pkg::SECONDARY_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   pmon_req_if.sink                            req_ch,
   pmon_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [pmon_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pmon_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pmon_pkg::*;

   localparam int MODULE_SUM   = PRIMARY_COUNT + SECONDARY_COUNT;
   localparam int MODULE_COUNT = (MODULE_SUM > MODULE_MAX) ? MODULE_MAX : MODULE_SUM;

   // Configuration registers
   logic [MASK_W-1:0] pmask_ff;
   logic [CNT_W-1:0]  ptimeout_ff;
   logic [CNT_W-1:0]  stimeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pmask_ff    <= MASK_RESET;
         ptimeout_ff <= TIMEOUT_RESET;
         stimeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRIMARY_VALID_MASK:      pmask_ff    <= csr_wdata[MASK_W-1:0];
            CSR_PRIMARY_TIMEOUT_TICKS:   ptimeout_ff <= csr_wdata[CNT_W-1:0];
            CSR_SECONDARY_TIMEOUT_TICKS: stimeout_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer state
   state_type              state_ff, state_in;
   logic [MODULE_ID_W-1:0] idx_ff,   idx_in;

   logic                   req_accept;
   logic                   tick_start;
   logic                   load_rsp;
   logic                   take_event;
   logic                   out_free;
   logic                   later_pend;
   logic [MODULE_MAX-1:0]  above_mask;

   // Cell row
   logic [MODULE_COUNT:0]   token;
   logic [MODULE_MAX-1:0]   active_vec;
   logic [MODULE_MAX-1:0]   pend_vec;
   logic [MODULE_MAX-1:0]   kind_vec;

   assign token[0] = tick_start;

   for (genvar i = 0; i < MODULE_MAX; i++) begin : g_cell
      if (i < MODULE_COUNT) begin : g_used
         pmon_cell_ctl_type ctl;
         pmon_cell_sts_type sts;
         logic              mon;

         if (i >= PRIMARY_COUNT) begin : g_sec
            assign mon = 1'b1;
         end else if (i < MASK_W) begin : g_pri
            assign mon = pmask_ff[i];
         end else begin : g_pri_nomask
            assign mon = 1'b0;
         end

         assign ctl.set_seen = req_accept && (op_type'(req_ch.opcode) == OP_HEARTBEAT)
                               && (req_ch.module_id == MODULE_ID_W'(i));
         assign ctl.clr_seen = req_accept && (op_type'(req_ch.opcode) == OP_CLEAR)
                               && (req_ch.module_id == MODULE_ID_W'(i));
         assign ctl.take     = take_event && (idx_ff == MODULE_ID_W'(i));

         pmon_cell #(
            .IS_PRIMARY (i < PRIMARY_COUNT)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .token_in  (token[i]),
            .token_out (token[i+1]),
            .mon       (mon),
            .timeout   ((i < PRIMARY_COUNT) ? ptimeout_ff : stimeout_ff),
            .ctl       (ctl),
            .sts       (sts)
         );

         assign active_vec[i] = sts.active;
         assign pend_vec[i]   = sts.pend;
         assign kind_vec[i]   = sts.kind;
      end else begin : g_unused
         assign active_vec[i] = 1'b0;
         assign pend_vec[i]   = 1'b0;
         assign kind_vec[i]   = 1'b0;
      end
   end

   // Pending events beyond the scan pointer
   always_comb begin
      for (int j = 0; j < MODULE_MAX; j++) begin
         above_mask[j] = (MODULE_ID_W'(j) > idx_ff);
      end
   end
   assign later_pend = |(pend_vec & above_mask);

   assign req_accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE);

   // Output register
   logic                   rsp_valid_ff;
   logic                   rsp_evt_ff,    rsp_evt_in;
   logic                   rsp_kind_ff,   rsp_kind_in;
   logic [MODULE_ID_W-1:0] rsp_module_ff, rsp_module_in;
   logic [MODULE_MAX-1:0]  rsp_active_ff;
   logic                   rsp_last_ff,   rsp_last_in;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Next state, scan pointer and result selection
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      tick_start    = 1'b0;
      load_rsp      = 1'b0;
      take_event    = 1'b0;
      rsp_evt_in    = 1'b0;
      rsp_kind_in   = KIND_RESPONDS;
      rsp_module_in = '0;
      rsp_last_in   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_accept) begin
               if (op_type'(req_ch.opcode) == OP_TICK) begin
                  tick_start = 1'b1;
                  state_in   = ST_SWEEP;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SWEEP: begin
            if (token[MODULE_COUNT]) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            priority if (pend_vec == '0) begin
               if (out_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (!pend_vec[idx_ff]) begin
               idx_in = idx_ff + MODULE_ID_W'(1);
            end else if (out_free) begin
               load_rsp      = 1'b1;
               take_event    = 1'b1;
               rsp_evt_in    = 1'b1;
               rsp_kind_in   = kind_vec[idx_ff];
               rsp_module_in = idx_ff;
               rsp_last_in   = !later_pend;
               if (later_pend) begin
                  idx_in = idx_ff + MODULE_ID_W'(1);
               end else begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end
            end else begin
               // hold the scan while the receiver stalls
               idx_in = idx_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   // Load a result, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_evt_ff    <= rsp_evt_in;
         rsp_kind_ff   <= rsp_kind_in;
         rsp_module_ff <= rsp_module_in;
         rsp_active_ff <= active_vec;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.event_valid  = rsp_evt_ff;
   assign rsp_ch.event_kind   = rsp_kind_ff;
   assign rsp_ch.event_module = rsp_module_ff;
   assign rsp_ch.active_mask  = rsp_active_ff;
   assign rsp_ch.last_result  = rsp_last_ff;

endmodule
